/* hdl/uartrx_pkg.sv */
package uartrx_pkg;

  // Default number of bytes held by the receive FIFO.
  localparam int BUF_DEPTH_DEF = 32;

  // Field widths of the input and result items.
  localparam int ACTION_W = 3;
  localparam int BYTE_W   = 8;
  localparam int COUNT_W  = 16;
  localparam int KIND_W   = 2;
  localparam int POS_W    = 16;

  // Input action codes.
  localparam logic [ACTION_W-1:0] ACT_RX_BYTE   = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_POP_ONE   = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_POP_COUNT = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_BLK_START = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_BLK_QUERY = 3'd4;
  localparam logic [ACTION_W-1:0] ACT_BLK_CANCEL = 3'd5;

  // Result kinds.
  localparam logic [KIND_W-1:0] KIND_BLK_WRITE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_POP_BYTE  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_STATUS    = 2'd2;

endpackage

/* hdl/uart_rx_fifo_with_block_mode_unit.sv */
// UART receive buffer with a block-receive mode.
// Input channel (in_valid / in_stall) carries action, rx_byte and count; the
// output channel (out_valid / out_stall) carries result_kind, data, position,
// ok and last. A transfer happens on a rising edge with valid high, stall low.
// Received bytes are stored in a BUF_DEPTH-entry synchronous RAM; in block
// mode they are forwarded instead as block writes at a running position.
// An item accepted at a rising edge shows its first result in the next
// cycle from the output register. A byte stored in normal mode gives no
// result. A multi-pop of n bytes emits one byte per cycle while the
// receiver does not stall the output, because the RAM read of the next
// head entry is issued while the current byte is loaded; the input stays
// stalled until the last byte is in the output register. The input is also
// stalled while the output register holds a result not yet taken.
// Reset (rst, synchronous) empties the FIFO, leaves block mode and clears
// position and size; RAM contents are not cleared. When the receiver
// asserts out_stall, the result and everything behind it simply wait.
module uart_rx_fifo_with_block_mode_unit #(
  parameter int BUF_DEPTH = uartrx_pkg::BUF_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [uartrx_pkg::ACTION_W-1:0]   action,
  input  logic [uartrx_pkg::BYTE_W-1:0]     rx_byte,
  input  logic [uartrx_pkg::COUNT_W-1:0]    count,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [uartrx_pkg::KIND_W-1:0]     result_kind,
  output logic [uartrx_pkg::BYTE_W-1:0]     data,
  output logic [uartrx_pkg::POS_W-1:0]      position,
  output logic                              ok,
  output logic                              last
);
  import uartrx_pkg::*;

  localparam int PTR_W  = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
  localparam int FILL_W = $clog2(BUF_DEPTH + 1);
  localparam logic [PTR_W-1:0]  PTR_LAST  = PTR_W'(BUF_DEPTH - 1);
  localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(BUF_DEPTH);

  // Controller states.
  localparam logic S_IDLE = 1'b0;
  localparam logic S_POP  = 1'b1;

  logic              state, state_next;
  logic [PTR_W-1:0]  head, head_next;
  logic [PTR_W-1:0]  tail, tail_next;
  logic [FILL_W-1:0] fill, fill_next;
  logic [FILL_W-1:0] remaining, remaining_next;
  logic              block_active, block_active_next;
  logic [POS_W-1:0]  block_position, block_position_next;
  logic [POS_W-1:0]  block_size, block_size_next;

  logic [BYTE_W-1:0] mem [BUF_DEPTH];
  logic [BYTE_W-1:0] rd_data;

  logic              in_xfer;
  logic              out_free;
  logic              out_load;
  logic              wr_en;
  logic              pop_en;
  logic [POS_W-1:0]  pos_inc;
  logic [KIND_W-1:0] kind_d;
  logic [BYTE_W-1:0] data_d;
  logic [POS_W-1:0]  position_d;
  logic              ok_d;
  logic              last_d;

  // The output register is free when empty or being taken this cycle.
  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != S_IDLE) || !out_free;
  assign in_xfer  = in_valid && !in_stall;
  assign pos_inc  = block_position + POS_W'(1);

  // Decode the accepted item or the next byte of a multi-pop.
  always_comb begin
    state_next          = state;
    head_next           = head;
    tail_next           = tail;
    fill_next           = fill;
    remaining_next      = remaining;
    block_active_next   = block_active;
    block_position_next = block_position;
    block_size_next     = block_size;
    wr_en      = 1'b0;
    pop_en     = 1'b0;
    out_load   = 1'b0;
    kind_d     = KIND_STATUS;
    data_d     = '0;
    position_d = '0;
    ok_d       = 1'b0;
    last_d     = 1'b1;

    case (state)
      S_IDLE: begin
        if (in_xfer) begin
          case (action)
            ACT_RX_BYTE: begin
              if (block_active) begin
                out_load            = 1'b1;
                kind_d              = KIND_BLK_WRITE;
                data_d              = rx_byte;
                position_d          = block_position;
                block_position_next = pos_inc;
                if (pos_inc >= block_size) begin
                  block_active_next = 1'b0;
                end
              end else if (fill != FILL_FULL) begin
                wr_en = 1'b1;
              end
            end
            ACT_POP_ONE: begin
              out_load = 1'b1;
              kind_d   = KIND_POP_BYTE;
              if (fill != '0) begin
                pop_en = 1'b1;
                data_d = rd_data;
                ok_d   = 1'b1;
              end
            end
            ACT_POP_COUNT: begin
              out_load = 1'b1;
              if (count == '0) begin
                ok_d = 1'b1;
              end else if (COUNT_W'(fill) >= count) begin
                // Enough bytes held: emit the first one now, the rest in S_POP.
                pop_en         = 1'b1;
                kind_d         = KIND_POP_BYTE;
                data_d         = rd_data;
                ok_d           = 1'b1;
                last_d         = (count == COUNT_W'(1));
                remaining_next = FILL_W'(count) - FILL_W'(1);
                if (count != COUNT_W'(1)) begin
                  state_next = S_POP;
                end
              end
            end
            ACT_BLK_START: begin
              out_load            = 1'b1;
              block_active_next   = 1'b1;
              block_position_next = '0;
              block_size_next     = count;
            end
            ACT_BLK_QUERY: begin
              out_load   = 1'b1;
              position_d = block_position;
            end
            ACT_BLK_CANCEL: begin
              out_load            = 1'b1;
              block_active_next   = 1'b0;
              block_position_next = '0;
              block_size_next     = '0;
            end
            default: begin
            end
          endcase
        end
      end
      S_POP: begin
        if (out_free) begin
          out_load       = 1'b1;
          pop_en         = 1'b1;
          kind_d         = KIND_POP_BYTE;
          data_d         = rd_data;
          ok_d           = 1'b1;
          last_d         = (remaining == FILL_W'(1));
          remaining_next = remaining - FILL_W'(1);
          if (remaining == FILL_W'(1)) begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    // Pointer and fill bookkeeping.
    if (pop_en) begin
      head_next = (head == PTR_LAST) ? '0 : head + PTR_W'(1);
    end
    if (wr_en) begin
      tail_next = (tail == PTR_LAST) ? '0 : tail + PTR_W'(1);
    end
    if (wr_en && !pop_en) begin
      fill_next = fill + FILL_W'(1);
    end else if (pop_en && !wr_en) begin
      fill_next = fill - FILL_W'(1);
    end
  end

  // Byte store. The read always targets the next head entry, so rd_data holds
  // the head byte. A write to that entry (only when empty) is forwarded.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[tail] <= rx_byte;
    end
    if (wr_en && (tail == head_next)) begin
      rd_data <= rx_byte;
    end else begin
      rd_data <= mem[head_next];
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      head           <= '0;
      tail           <= '0;
      fill           <= '0;
      remaining      <= '0;
      block_active   <= 1'b0;
      block_position <= '0;
      block_size     <= '0;
      out_valid      <= 1'b0;
    end else begin
      state          <= state_next;
      head           <= head_next;
      tail           <= tail_next;
      fill           <= fill_next;
      remaining      <= remaining_next;
      block_active   <= block_active_next;
      block_position <= block_position_next;
      block_size     <= block_size_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Output payload register.
  always_ff @(posedge clk) begin
    if (out_load) begin
      result_kind <= kind_d;
      data        <= data_d;
      position    <= position_d;
      ok          <= ok_d;
      last        <= last_d;
    end
  end

  // The fill count never passes the FIFO depth.
  assert property (@(posedge clk) disable iff (rst) fill <= FILL_FULL)
    else $error("FIFO fill count exceeds depth");

  // A multi-pop in progress always has bytes left and enough bytes held.
  assert property (@(posedge clk) disable iff (rst)
    (state == S_POP) |-> ((remaining != '0) && (fill >= remaining)))
    else $error("multi-pop remaining count out of range");

  // A result without the last mark is only ever followed by more pop bytes.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !last) |-> (state == S_POP))
    else $error("non-final result outside a multi-pop");

  // A new item is never taken while a multi-pop is still emitting.
  assert property (@(posedge clk) disable iff (rst)
    (state == S_POP) |-> in_stall)
    else $error("input accepted during multi-pop");

endmodule
